// ----- design/shell_quote_tokenizer_defines.svh -----
// assertion macros shared by the tokenizer modules
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SHELL_QUOTE_TOKENIZER_DEFINES_SVH
`define SHELL_QUOTE_TOKENIZER_DEFINES_SVH

// property must hold at every rising clock edge out of reset
`define SQT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// expression must never be true out of reset
`define SQT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ----- design/sqt_pkg.sv -----
// types and constants of the shell quote tokenizer
// no dependencies
package sqt_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SINGLE = 3'd1,
    MODE_DOUBLE = 3'd2,
    MODE_ESC_N  = 3'd3,
    MODE_ESC_D  = 3'd4,
    MODE_GT     = 3'd5
  } sqt_mode_e;

  localparam logic [2:0] KIND_CHAR   = 3'd0;
  localparam logic [2:0] KIND_WEND   = 3'd1;
  localparam logic [2:0] KIND_REDIR  = 3'd2;
  localparam logic [2:0] KIND_APPEND = 3'd3;
  localparam logic [2:0] KIND_DONE   = 3'd4;

  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SQ = 8'h27;
  localparam logic [7:0] CH_DQ = 8'h22;
  localparam logic [7:0] CH_BS = 8'h5C;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_N  = 8'h6E;
  localparam logic [7:0] CH_T  = 8'h74;
  localparam logic [7:0] CH_R  = 8'h72;

  // results one character can cause
  localparam int unsigned MaxRes = 4;
  localparam int unsigned SlotW  = $clog2(MaxRes);
  localparam int unsigned CntW   = $clog2(MaxRes + 1);

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_line;
  } sqt_in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_char;
    logic       single_quoted;
    logic       last_of_run;
  } sqt_out_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_char;
    logic       single_quoted;
  } sqt_slot_t;

  // all results of one character, slot 0 first
  typedef struct packed {
    logic [CntW-1:0]           cnt;
    sqt_slot_t [MaxRes-1:0]    slot;
  } sqt_bundle_t;

  typedef struct packed {
    logic empty;
    logic full;
  } sqt_q_stat_t;

endpackage

// ----- design/sqt_front.sv -----
// front end: lexer state and classification of each character into a result bundle
// depends on sqt_pkg and shell_quote_tokenizer_defines.svh
`include "shell_quote_tokenizer_defines.svh"

module sqt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sqt_pkg::sqt_in_t    in_data_i,
  input  sqt_pkg::sqt_q_stat_t q_stat_i,
  output logic                wr_en_o,
  output sqt_pkg::sqt_bundle_t wr_bnd_o
);
  import sqt_pkg::*;

  typedef struct packed {
    sqt_mode_e   mode;
    logic        nonempty;
    logic        single;
    sqt_bundle_t bnd;
  } sqt_lex_t;

  function automatic sqt_lex_t put_res(sqt_lex_t s, logic [2:0] k, logic [7:0] c, logic sq);
    sqt_lex_t r;
    r = s;
    r.bnd.slot[s.bnd.cnt[SlotW-1:0]] = '{kind: k, out_char: c, single_quoted: sq};
    r.bnd.cnt = s.bnd.cnt + CntW'(1);
    return r;
  endfunction

  function automatic sqt_lex_t add_char(sqt_lex_t s, logic [7:0] c);
    sqt_lex_t r;
    r = put_res(s, KIND_CHAR, c, 1'b0);
    r.nonempty = 1'b1;
    return r;
  endfunction

  function automatic sqt_lex_t end_word(sqt_lex_t s);
    sqt_lex_t r;
    r = s;
    if (s.nonempty) begin
      r = put_res(s, KIND_WEND, 8'h00, s.single);
    end
    r.nonempty = 1'b0;
    r.single   = 1'b0;
    return r;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SP) || ((c >= CH_HT) && (c <= CH_CR));
  endfunction

  function automatic sqt_lex_t lex_step(sqt_lex_t s, logic [7:0] c, logic eol);
    sqt_lex_t   r;
    logic       do_norm;
    logic [7:0] m;
    r       = s;
    do_norm = 1'b0;
    m       = c;
    case (s.mode)
      MODE_SINGLE: begin
        r = add_char(r, c);
        if (c == CH_SQ) r.mode = MODE_NORMAL;
      end
      MODE_DOUBLE: begin
        if (c == CH_BS) begin
          r.mode = MODE_ESC_D;
        end else begin
          r = add_char(r, c);
          if (c == CH_DQ) r.mode = MODE_NORMAL;
        end
      end
      MODE_ESC_N: begin
        r = add_char(r, c);
        r.mode = MODE_NORMAL;
      end
      MODE_ESC_D: begin
        if (c == CH_N) m = CH_LF;
        else if (c == CH_T) m = CH_HT;
        else if (c == CH_R) m = CH_CR;
        r = add_char(r, m);
        r.mode = MODE_DOUBLE;
      end
      MODE_GT: begin
        r.mode = MODE_NORMAL;
        if (c == CH_GT) begin
          r = put_res(r, KIND_APPEND, 8'h00, 1'b0);
        end else begin
          r = put_res(r, KIND_REDIR, 8'h00, 1'b0);
          do_norm = 1'b1;
        end
      end
      default: begin
        r.mode  = MODE_NORMAL;
        do_norm = 1'b1;
      end
    endcase
    if (do_norm) begin
      if (is_ws(c)) begin
        r = end_word(r);
      end else if (c == CH_SQ) begin
        r = add_char(r, c);
        r.single = 1'b1;
        r.mode   = MODE_SINGLE;
      end else if (c == CH_DQ) begin
        r = add_char(r, c);
        r.mode = MODE_DOUBLE;
      end else if (c == CH_BS) begin
        r.mode = MODE_ESC_N;
      end else if (c == CH_GT) begin
        r = end_word(r);
        r.mode = MODE_GT;
      end else begin
        r = add_char(r, c);
      end
    end
    if (eol) begin
      if (r.mode == MODE_GT) r = put_res(r, KIND_REDIR, 8'h00, 1'b0);
      r = end_word(r);
      r = put_res(r, KIND_DONE, 8'h00, 1'b0);
      r.mode     = MODE_NORMAL;
      r.nonempty = 1'b0;
      r.single   = 1'b0;
    end
    return r;
  endfunction

  sqt_mode_e mode_q, mode_d;
  logic      nonempty_q, nonempty_d;
  logic      single_q, single_d;
  logic      accept;
  sqt_lex_t  cur, step_s;

  assign accept = push_i && !q_stat_i.full;

  always_comb begin
    cur.mode     = mode_q;
    cur.nonempty = nonempty_q;
    cur.single   = single_q;
    cur.bnd      = '0;
    step_s       = lex_step(cur, in_data_i.ch, in_data_i.end_of_line);
  end

  // next state
  always_comb begin
    mode_d     = mode_q;
    nonempty_d = nonempty_q;
    single_d   = single_q;
    if (accept) begin
      mode_d     = step_s.mode;
      nonempty_d = step_s.nonempty;
      single_d   = step_s.single;
    end
  end

  // outputs: characters with no result never enter the queue
  always_comb begin
    wr_en_o  = accept && (step_s.bnd.cnt != '0);
    wr_bnd_o = step_s.bnd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_NORMAL;
      nonempty_q <= 1'b0;
      single_q   <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      nonempty_q <= nonempty_d;
      single_q   <= single_d;
    end
  end

  `SQT_ASSERT(a_eol_resets, accept && in_data_i.end_of_line |=> mode_q == MODE_NORMAL && !nonempty_q && !single_q, "line end left lexer state behind")
  `SQT_ASSERT(a_bundle_size, wr_en_o |-> wr_bnd_o.cnt <= CntW'(MaxRes), "bundle larger than slots")
  `SQT_ASSERT(a_single_needs_word, single_q |-> nonempty_q, "single quote flag without word text")

endmodule

// ----- design/sqt_fifo.sv -----
// bundle queue between the front end and the back end
// depends on sqt_pkg and shell_quote_tokenizer_defines.svh
`include "shell_quote_tokenizer_defines.svh"

module sqt_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  sqt_pkg::sqt_bundle_t wr_bnd_i,
  input  logic                 rd_en_i,
  output sqt_pkg::sqt_bundle_t rd_bnd_o,
  output sqt_pkg::sqt_q_stat_t q_stat_o
);
  import sqt_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  sqt_bundle_t   mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign q_stat_o.full  = (count_q == CW'(Depth));
  assign q_stat_o.empty = (count_q == '0);
  assign rd_bnd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (wr_en_i && !rd_en_i) count_d = count_q + CW'(1);
    else if (rd_en_i && !wr_en_i) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_ptr_q] <= wr_bnd_i;
  end

  `SQT_ASSERT_NEVER(a_no_overflow, wr_en_i && q_stat_o.full, "write into full queue")
  `SQT_ASSERT_NEVER(a_no_underflow, rd_en_i && q_stat_o.empty, "read from empty queue")
  `SQT_ASSERT(a_ptr_gap, q_stat_o.empty |-> wr_ptr_q == rd_ptr_q, "pointers apart while empty")

endmodule

// ----- design/sqt_back.sv -----
// back end: walks the slots of the head bundle into the result register
// depends on sqt_pkg and shell_quote_tokenizer_defines.svh
`include "shell_quote_tokenizer_defines.svh"

module sqt_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sqt_pkg::sqt_bundle_t head_i,
  input  sqt_pkg::sqt_q_stat_t q_stat_i,
  output logic                 rd_en_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output sqt_pkg::sqt_out_t    out_data_o
);
  import sqt_pkg::*;

  logic [SlotW-1:0] idx_q, idx_d;
  logic             valid_q, valid_d;
  sqt_out_t         out_q;
  logic             load, last;
  sqt_slot_t        cur_slot;

  assign cur_slot = head_i.slot[idx_q];
  assign last     = (CntW'(idx_q) + CntW'(1)) == head_i.cnt;
  // result register free now or emptied by this beat
  assign load     = !q_stat_i.empty && (!valid_q || pop_i);
  assign rd_en_o  = load && last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = last ? '0 : idx_q + SlotW'(1);
      valid_d = 1'b1;
    end else if (pop_i && valid_q) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.kind          <= cur_slot.kind;
      out_q.out_char      <= cur_slot.out_char;
      out_q.single_quoted <= cur_slot.single_quoted;
      out_q.last_of_run   <= last;
    end
  end

  assign empty_o    = !valid_q;
  assign out_data_o = out_q;

  `SQT_ASSERT_NEVER(a_mid_bundle, (idx_q != '0) && q_stat_i.empty, "bundle left mid-walk")
  `SQT_ASSERT(a_idx_in_range, !q_stat_i.empty |-> CntW'(idx_q) < head_i.cnt, "slot index past bundle")
  `SQT_ASSERT(a_hold_stall, valid_q && !pop_i |=> valid_q && $stable(out_q), "stalled result changed")

endmodule

// ----- design/shell_quote_tokenizer.sv -----
// top level of the shell quote tokenizer: front end, bundle queue, back end
// depends on sqt_pkg, sqt_front, sqt_fifo and sqt_back
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | push / full         | in_data_i  (ch, end_of_line)
//  result   | empty / pop         | out_data_o (kind, out_char, single_quoted,
//           |                     |             last_of_run)
//
// one character is taken per cycle while the bundle queue has room
// the back end moves one result per cycle out of the head bundle while the result
// register is free or being popped; a character has 0 to 4 results, and
// characters with no result never enter the queue
// the first result of a character is written into the bundle queue and then into the
// result register before it shows on the outputs; reset empties the queue
// a stalled pop backs up into the queue and then raises full
module shell_quote_tokenizer #(
  parameter int unsigned QDepth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  sqt_pkg::sqt_in_t  in_data_i,
  output logic              empty,
  input  logic              pop,
  output sqt_pkg::sqt_out_t out_data_o
);
  import sqt_pkg::*;

  sqt_q_stat_t q_stat;
  sqt_bundle_t wr_bnd, head_bnd;
  logic        wr_en, rd_en;

  sqt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_data_i (in_data_i),
    .q_stat_i  (q_stat),
    .wr_en_o   (wr_en),
    .wr_bnd_o  (wr_bnd)
  );

  sqt_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_bnd_i (wr_bnd),
    .rd_en_i  (rd_en),
    .rd_bnd_o (head_bnd),
    .q_stat_o (q_stat)
  );

  sqt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_bnd),
    .q_stat_i   (q_stat),
    .rd_en_o    (rd_en),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_data_o (out_data_o)
  );

  assign full = q_stat.full;

endmodule
